// File: hw/rtl/toroidal_nearest_seed_search_assert.svh
// Assertion macros used by the port-level checker of the nearest seed search.
// Each macro expects i_clk and i_rst_n in scope; no other dependencies.
`ifndef TOROIDAL_NEAREST_SEED_SEARCH_ASSERT_SVH
`define TOROIDAL_NEAREST_SEED_SEARCH_ASSERT_SVH

// Same-cycle implication, idle in reset.
`define TNSS_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tnss assertion failed");

// Next-cycle implication, idle in reset.
`define TNSS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tnss assertion failed");

`endif

// File: hw/rtl/tnss_pkg.sv
// Package for the nearest seed search: field widths, codes and constants.
// No dependencies; used by every module of the block except tnss_ram.
package tnss_pkg;

    localparam int COORD_W    = 7;
    localparam int SEED_W     = 3 * COORD_W;
    localparam int LABEL_W    = 8;
    localparam int SLOT_W     = 8;
    localparam int GRID_W     = 8;
    localparam int COUNT_W    = 9;
    localparam int DIST_W     = 14;
    localparam int SQ_W       = 2 * GRID_W;
    localparam int SUM_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [GRID_W-1:0]  GRID_RESET  = GRID_W'(16);
    localparam logic [DIST_W-1:0]  DIST_SAT    = '1;
    localparam logic [SUM_W-1:0]   SUM_NONE    = '1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_LENGTH = 2'd0,
        CFG_POINT_COUNT = 2'd1
    } t_cfg_reg;

endpackage

// File: hw/rtl/tnss_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tnss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/tnss_axis_cell.sv
// One cell of the distance chain: folds one axis difference on the torus,
// squares it and adds it to the running sum. Depends on tnss_pkg.
module tnss_axis_cell (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [tnss_pkg::COORD_W-1:0]  i_query_coord,
    input  logic [tnss_pkg::GRID_W-1:0]   i_grid_length,
    input  logic [tnss_pkg::SEED_W-1:0]   i_seed,
    input  logic [tnss_pkg::SUM_W-1:0]    i_sum,
    output logic [tnss_pkg::SEED_W-1:0]   o_seed,
    output logic [tnss_pkg::SUM_W-1:0]    o_sum
);
    import tnss_pkg::*;

    logic [COORD_W-1:0] r_query;
    logic [SEED_W-1:0]  r_seed;
    logic [SUM_W-1:0]   r_sum;

    logic [COORD_W-1:0] seed_coord;
    logic [COORD_W-1:0] diff;
    logic [GRID_W-1:0]  diff_ext;
    logic [GRID_W-1:0]  half;
    logic [GRID_W-1:0]  wrap;
    logic [GRID_W-1:0]  folded;
    logic [SQ_W-1:0]    sq;

    // fold: |a-b|, then length minus that when past half the cube
    always_comb begin
        seed_coord = i_seed[COORD_W-1:0];
        diff       = (seed_coord >= r_query) ? seed_coord - r_query : r_query - seed_coord;
        diff_ext   = GRID_W'(diff);
        half       = i_grid_length >> 1;
        // magnitude of (length - diff); a negative value squares the same
        wrap       = (i_grid_length >= diff_ext) ? i_grid_length - diff_ext
                                                 : diff_ext - i_grid_length;
        folded     = (diff_ext > half) ? wrap : diff_ext;
        sq         = folded * folded;
    end

    // query coordinate held for the whole scan; seed word shifts one axis on
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_query <= i_query_coord;
        end
        r_seed <= {{COORD_W{1'b0}}, i_seed[SEED_W-1:COORD_W]};
        r_sum  <= i_sum + SUM_W'(sq);
    end

    assign o_seed = r_seed;
    assign o_sum  = r_sum;

endmodule

// File: hw/rtl/toroidal_nearest_seed_search.sv
// Top level of the nearest seed search on a periodic cube.
// Depends on tnss_pkg, tnss_ram and tnss_axis_cell.
//
//  channel | handshake                   | payload
//  cfg     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//  in      | i_in_valid  / o_in_ready    | i_operation, i_slot, i_coord_x/y/z, i_label
//  out     | o_out_valid / i_out_ready   | o_nearest_index/label/distance, o_table_empty
//
// A load item gives no result and leaves the input ready. With N = min(point_count,
// MAX_SEEDS) a query reads the first N seeds of the table in slot order; each one
// passes the RAM read register and the chain of axis cells, the compare updates the
// running best, and the result loads the output register once that is free. The
// input is not ready again until the result is registered; an empty search goes
// straight from the query to loading its result.
// Reset is synchronous; the seed table is not cleared. A stalled result holds
// in the output register and the block waits before loading the next one.
module toroidal_nearest_seed_search #(
    parameter int MAX_SEEDS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tnss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tnss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [tnss_pkg::SLOT_W-1:0]       i_slot,
    input  logic [tnss_pkg::COORD_W-1:0]      i_coord_x,
    input  logic [tnss_pkg::COORD_W-1:0]      i_coord_y,
    input  logic [tnss_pkg::COORD_W-1:0]      i_coord_z,
    input  logic [tnss_pkg::LABEL_W-1:0]      i_label,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [tnss_pkg::SLOT_W-1:0]       o_nearest_index,
    output logic [tnss_pkg::LABEL_W-1:0]      o_nearest_label,
    output logic [tnss_pkg::DIST_W-1:0]       o_nearest_distance,
    output logic                              o_table_empty
);
    import tnss_pkg::*;

    localparam int IDX_W  = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int CNT_W0 = $clog2(MAX_SEEDS + 1);
    localparam int CW     = (CNT_W0 > COUNT_W) ? CNT_W0 : COUNT_W;
    localparam int WORD_W = LABEL_W + SEED_W;
    localparam int NCELL  = 3;
    localparam int PIPE   = NCELL + 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SEEDS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    // control and configuration
    t_state             r_state;
    logic [GRID_W-1:0]  r_grid_length;
    logic [COUNT_W-1:0] r_point_count;
    logic [CW-1:0]      r_issue;
    logic [CW-1:0]      r_count;

    // result register
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_nearest_index;
    logic [LABEL_W-1:0] r_nearest_label;
    logic [DIST_W-1:0]  r_nearest_distance;
    logic               r_table_empty;

    // tags travelling beside the cell chain
    logic               r_tv  [PIPE];
    logic               r_tl  [PIPE];
    logic [IDX_W-1:0]   r_ti  [PIPE];
    logic [LABEL_W-1:0] r_lab [PIPE-1];

    // running best
    logic [SUM_W-1:0]   r_best_dist;
    logic [IDX_W-1:0]   r_best_idx;
    logic [LABEL_W-1:0] r_best_label;
    logic               r_empty;

    logic               in_acc;
    logic               query_acc;
    logic               load_acc;
    logic               out_free;
    logic               scan_last;
    logic [CW-1:0]      slot_ext;
    logic [CW-1:0]      pc_ext;
    logic [CW-1:0]      n_count;
    logic [WORD_W-1:0]  ram_rdata;
    logic [SEED_W-1:0]  query_word;
    logic [SEED_W-1:0]  c_seed [NCELL+1];
    logic [SUM_W-1:0]   c_sum  [NCELL+1];
    logic [DIST_W-1:0]  dist_sat;
    logic [IDX_W+SLOT_W-1:0] idx_wide;

    // handshakes and decode
    always_comb begin
        in_acc    = i_in_valid && o_in_ready;
        query_acc = in_acc && (t_op'(i_operation) == OP_QUERY);
        slot_ext  = CW'(i_slot);
        load_acc  = in_acc && (t_op'(i_operation) == OP_LOAD) && (slot_ext < MAX_C);
        out_free  = !r_out_valid || i_out_ready;
        pc_ext    = CW'(r_point_count);
        n_count   = (pc_ext > MAX_C) ? MAX_C : pc_ext;
        scan_last = (r_issue == r_count - CW'(1));
    end

    // seed table: {label, z, y, x}
    tnss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_SEEDS)
    ) u_seed_ram (
        .i_clk   (i_clk),
        .i_we    (load_acc),
        .i_waddr (slot_ext[IDX_W-1:0]),
        .i_wdata ({i_label, i_coord_z, i_coord_y, i_coord_x}),
        .i_re    (r_state == S_SCAN),
        .i_raddr (r_issue[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // chain of axis cells, x first
    assign query_word = {i_coord_z, i_coord_y, i_coord_x};
    assign c_seed[0]  = ram_rdata[SEED_W-1:0];
    assign c_sum[0]   = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        tnss_axis_cell u_cell (
            .i_clk         (i_clk),
            .i_load        (query_acc),
            .i_query_coord (query_word[k*COORD_W +: COORD_W]),
            .i_grid_length (r_grid_length),
            .i_seed        (c_seed[k]),
            .i_sum         (c_sum[k]),
            .o_seed        (c_seed[k+1]),
            .o_sum         (c_sum[k+1])
        );
    end

    // result shaping
    always_comb begin
        dist_sat = (r_best_dist > SUM_W'(DIST_SAT)) ? DIST_SAT : r_best_dist[DIST_W-1:0];
        idx_wide = {{SLOT_W{1'b0}}, r_best_idx};
    end

    // state machine, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_grid_length <= GRID_RESET;
            r_point_count <= '0;
            r_issue       <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_GRID_LENGTH: r_grid_length <= i_cfg_data[GRID_W-1:0];
                    CFG_POINT_COUNT: r_point_count <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            // result taken; in S_OUT the next result takes its place
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (query_acc) begin
                        r_issue <= '0;
                        r_count <= n_count;
                        r_state <= (n_count == '0) ? S_OUT : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_issue <= r_issue + CW'(1);
                    if (scan_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_tv[PIPE-1] && r_tl[PIPE-1]) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid        <= 1'b1;
                        r_nearest_index    <= idx_wide[SLOT_W-1:0];
                        r_nearest_label    <= r_best_label;
                        r_nearest_distance <= dist_sat;
                        r_table_empty      <= r_empty;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // tag pipeline and best tracking; strict compare keeps the lowest index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE; k++) begin
                r_tv[k] <= 1'b0;
            end
        end else begin
            r_tv[0] <= (r_state == S_SCAN);
            for (int k = 1; k < PIPE; k++) begin
                r_tv[k] <= r_tv[k-1];
            end
        end
        r_tl[0]  <= scan_last;
        r_ti[0]  <= r_issue[IDX_W-1:0];
        r_lab[0] <= ram_rdata[WORD_W-1 -: LABEL_W];
        for (int k = 1; k < PIPE; k++) begin
            r_tl[k] <= r_tl[k-1];
            r_ti[k] <= r_ti[k-1];
        end
        for (int k = 1; k < PIPE-1; k++) begin
            r_lab[k] <= r_lab[k-1];
        end
        if (query_acc) begin
            r_best_dist  <= SUM_NONE;
            r_best_idx   <= '0;
            r_best_label <= '0;
            r_empty      <= (n_count == '0);
        end else if (r_tv[PIPE-1] && (c_sum[NCELL] < r_best_dist)) begin
            r_best_dist  <= c_sum[NCELL];
            r_best_idx   <= r_ti[PIPE-1];
            r_best_label <= r_lab[PIPE-2];
        end
    end

    assign o_cfg_ready        = 1'b1;
    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_nearest_index    = r_nearest_index;
    assign o_nearest_label    = r_nearest_label;
    assign o_nearest_distance = r_nearest_distance;
    assign o_table_empty      = r_table_empty;

endmodule

// File: hw/rtl/tnss_checker.sv
// Port-level checker for the nearest seed search, bound to the top level.
// Depends on tnss_pkg and toroidal_nearest_seed_search_assert.svh.
`include "toroidal_nearest_seed_search_assert.svh"

module tnss_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              i_operation,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [tnss_pkg::SLOT_W-1:0]       o_nearest_index,
    input logic [tnss_pkg::LABEL_W-1:0]      o_nearest_label,
    input logic [tnss_pkg::DIST_W-1:0]       o_nearest_distance,
    input logic                              o_table_empty
);
    import tnss_pkg::*;

    // an empty search reports slot 0, label 0 and the saturated distance
    `TNSS_ASSERT_IMPLY(a_empty_result, o_out_valid && o_table_empty, o_nearest_distance == DIST_SAT && o_nearest_index == '0 && o_nearest_label == '0)

    // a load item never stalls the input side
    `TNSS_ASSERT_NEXT(a_load_no_stall, i_in_valid && o_in_ready && i_operation == OP_LOAD, o_in_ready)

    // a query item keeps the input side busy while it is searched
    `TNSS_ASSERT_NEXT(a_query_busy, i_in_valid && o_in_ready && i_operation == OP_QUERY, !o_in_ready)

    // a stalled result item holds
    `TNSS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_nearest_distance) && $stable(o_nearest_index))

endmodule

bind toroidal_nearest_seed_search tnss_checker u_tnss_checker (.*);

// File: tb/toroidal_nearest_seed_search_checker.sv
// Checker for the nearest seed search: watches the three channels, keeps a
// shadow seed table and register set, predicts each query result and compares.
// Depends on tnss_pkg only.
module toroidal_nearest_seed_search_checker #(
    parameter int MAX_SEEDS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [tnss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tnss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_operation,
    input  logic [tnss_pkg::SLOT_W-1:0]       i_slot,
    input  logic [tnss_pkg::COORD_W-1:0]      i_coord_x,
    input  logic [tnss_pkg::COORD_W-1:0]      i_coord_y,
    input  logic [tnss_pkg::COORD_W-1:0]      i_coord_z,
    input  logic [tnss_pkg::LABEL_W-1:0]      i_label,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [tnss_pkg::SLOT_W-1:0]       i_nearest_index,
    input  logic [tnss_pkg::LABEL_W-1:0]      i_nearest_label,
    input  logic [tnss_pkg::DIST_W-1:0]       i_nearest_distance,
    input  logic                              i_table_empty,
    output int                                o_failures,
    output int                                o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tnss_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0]  index;
        logic [LABEL_W-1:0] label;
        logic [DIST_W-1:0]  distance;
        logic               empty;
    } t_nearest;

    // shadow of the block's table and registers
    logic [SEED_W-1:0]  seed_pos   [MAX_SEEDS];
    logic [LABEL_W-1:0] seed_label [MAX_SEEDS];
    logic [GRID_W-1:0]  grid_len;
    logic [COUNT_W-1:0] search_count;

    t_nearest expected_nearest [$];

    // one folded axis difference, squared; may fold negative when the difference exceeds the length
    function automatic int axis_sq(int a, int b, int len);
        int d;
        int half;
        d    = a - b;
        half = len >> 1;
        if (d < 0) d = -d;
        if (d > half) d = len - d;
        return d * d;
    endfunction

    // nearest seed among the searched slots, lowest slot on equal distance
    function automatic t_nearest search_nearest(logic [COORD_W-1:0] qx,
                                                logic [COORD_W-1:0] qy,
                                                logic [COORD_W-1:0] qz);
        t_nearest          r;
        int                n;
        int                best_dist;
        int                best_slot;
        int                d;
        int                len;
        logic [SEED_W-1:0] p;
        len = int'(grid_len);
        n   = (int'(search_count) > MAX_SEEDS) ? MAX_SEEDS : int'(search_count);
        if (n == 0) begin
            r.index    = '0;
            r.label    = '0;
            r.distance = DIST_SAT;
            r.empty    = 1'b1;
            return r;
        end
        best_dist = 32'h7fffffff;
        best_slot = 0;
        for (int i = 0; i < n; i++) begin
            p = seed_pos[i];
            d = axis_sq(int'(qx), int'(p[COORD_W-1:0]), len)
              + axis_sq(int'(qy), int'(p[2*COORD_W-1:COORD_W]), len)
              + axis_sq(int'(qz), int'(p[3*COORD_W-1:2*COORD_W]), len);
            if (d < best_dist) begin
                best_dist = d;
                best_slot = i;
            end
        end
        r.index    = SLOT_W'(best_slot);
        r.label    = seed_label[best_slot];
        r.distance = (best_dist > int'(DIST_SAT)) ? DIST_SAT : DIST_W'(best_dist);
        r.empty    = 1'b0;
        return r;
    endfunction

    // returns 1 on a mismatch and reports it
    function automatic int field_miss(string name, int want, int got);
        if (want == got) return 0;
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_nearest want;
        int       pushed;
        int       popped;
        int       bad;
        pushed = 0;
        popped = 0;
        bad    = 0;
        if (!i_rst_n) begin
            grid_len     = GRID_RESET;
            search_count = '0;
            expected_nearest.delete();
            o_failures    <= 0;
            o_outstanding <= 0;
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_GRID_LENGTH)
                    grid_len = i_cfg_data[GRID_W-1:0];
                else if (i_cfg_index == CFG_POINT_COUNT)
                    search_count = i_cfg_data[COUNT_W-1:0];
            end
            // accepted input item: load updates the table, query predicts
            if (i_in_valid && i_in_ready) begin
                if (i_operation == OP_LOAD) begin
                    if (int'(i_slot) < MAX_SEEDS) begin
                        seed_pos[i_slot]   = {i_coord_z, i_coord_y, i_coord_x};
                        seed_label[i_slot] = i_label;
                    end
                end else begin
                    expected_nearest.push_back(search_nearest(i_coord_x, i_coord_y,
                                                              i_coord_z));
                    pushed = 1;
                end
            end
            // accepted result item against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_nearest.size() == 0) begin
                    bad = 1;
                    $display("%0t ns: result expected none, got index %0d", $time,
                             i_nearest_index);
                end else begin
                    want   = expected_nearest.pop_front();
                    popped = 1;
                    bad += field_miss("nearest_index", want.index, i_nearest_index);
                    bad += field_miss("nearest_label", want.label, i_nearest_label);
                    bad += field_miss("nearest_distance", want.distance,
                                      i_nearest_distance);
                    bad += field_miss("table_empty", want.empty, i_table_empty);
                end
            end
            o_failures    <= o_failures + bad;
            o_outstanding <= o_outstanding + pushed - popped;
        end
    end

endmodule

// File: tb/toroidal_nearest_seed_search_test.sv
// Stimulus and verdict for the nearest seed search on a periodic cube.
// Depends on tnss_pkg, the block and toroidal_nearest_seed_search_checker.
module toroidal_nearest_seed_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tnss_pkg::*;

    localparam int MAX_SEEDS   = 256;
    localparam int ITEM_TARGET = 750;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 300;
    localparam int CYCLE_LIMIT = 1500000;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic                  i_operation   = 1'b0;
    logic [SLOT_W-1:0]     i_slot        = '0;
    logic [COORD_W-1:0]    i_coord_x     = '0;
    logic [COORD_W-1:0]    i_coord_y     = '0;
    logic [COORD_W-1:0]    i_coord_z     = '0;
    logic [LABEL_W-1:0]    i_label       = '0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic [SLOT_W-1:0]     o_nearest_index;
    logic [LABEL_W-1:0]    o_nearest_label;
    logic [DIST_W-1:0]     o_nearest_distance;
    logic                  o_table_empty;

    int failures;
    int outstanding;
    int cycle_count = 0;
    int items_sent  = 0;
    int grid_now    = 16;
    bit steady      = 1'b0;
    bit long_hold   = 1'b0;
    bit loaded [MAX_SEEDS];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    toroidal_nearest_seed_search #(.MAX_SEEDS(MAX_SEEDS)) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_slot             (i_slot),
        .i_coord_x          (i_coord_x),
        .i_coord_y          (i_coord_y),
        .i_coord_z          (i_coord_z),
        .i_label            (i_label),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_nearest_index    (o_nearest_index),
        .o_nearest_label    (o_nearest_label),
        .o_nearest_distance (o_nearest_distance),
        .o_table_empty      (o_table_empty)
    );

    toroidal_nearest_seed_search_checker #(.MAX_SEEDS(MAX_SEEDS)) nearest_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_slot             (i_slot),
        .i_coord_x          (i_coord_x),
        .i_coord_y          (i_coord_y),
        .i_coord_z          (i_coord_z),
        .i_label            (i_label),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_nearest_index    (o_nearest_index),
        .i_nearest_label    (o_nearest_label),
        .i_nearest_distance (o_nearest_distance),
        .i_table_empty      (o_table_empty),
        .o_failures         (failures),
        .o_outstanding      (outstanding)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("toroidal_nearest_seed_search: mismatch");
            $finish;
        end
    end

    // coordinate mostly inside the cube, sometimes anywhere in the field
    function automatic logic [COORD_W-1:0] rand_coord();
        if (grid_now >= 1 && grid_now <= 128 && $urandom_range(0, 9) < 8)
            return COORD_W'($urandom_range(0, grid_now - 1));
        return COORD_W'($urandom_range(0, 127));
    endfunction

    // offer one input item after a random gap and wait for it to be taken
    task automatic send_item(t_op op, logic [SLOT_W-1:0] slot, logic [COORD_W-1:0] x,
                             logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                             logic [LABEL_W-1:0] lbl);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (steady || r < 55)  gap = 0;
        else if (r < 85)       gap = $urandom_range(1, 3);
        else if (r < 97)       gap = $urandom_range(4, 10);
        else                   gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_slot      <= slot;
        i_coord_x   <= x;
        i_coord_y   <= y;
        i_coord_z   <= z;
        i_label     <= lbl;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_LOAD) loaded[slot] = 1'b1;
        items_sent++;
    endtask

    task automatic load_seed(logic [SLOT_W-1:0] slot, logic [COORD_W-1:0] x,
                             logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                             logic [LABEL_W-1:0] lbl);
        send_item(OP_LOAD, slot, x, y, z, lbl);
    endtask

    // slot and label are don't-care on a query but still toggled
    task automatic query_cell(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] z);
        send_item(OP_QUERY, SLOT_W'($urandom_range(0, 255)), x, y, z,
                  LABEL_W'($urandom_range(0, 255)));
    endtask

    // stop offering, wait for every result, then let a load finish
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // register write; only called with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_GRID_LENGTH) grid_now = int'(data[GRID_W-1:0]);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : out_ready_drive
        bit hold_done;
        int r;
        int len;
        hold_done = 1'b0;
        forever begin
            if (long_hold && !hold_done) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_out_ready <= 1'b1;
                    len = $urandom_range(1, 8);
                end else if (r < 65) begin
                    i_out_ready <= 1'b1;
                    len = $urandom_range(50, 150);
                end else if (r < 95) begin
                    i_out_ready <= 1'b0;
                    len = $urandom_range(1, 3);
                end else begin
                    i_out_ready <= 1'b0;
                    len = $urandom_range(20, 60);
                end
                // a requested hold-off cuts the current stretch short
                for (int k = 0; k < len && !(long_hold && !hold_done); k++)
                    @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int phase;
        int g;
        int c;
        int n;
        int n_items;
        int r;
        bit big;
        phase = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty search straight after reset
        query_cell(0, 0, 0);
        query_cell(127, 127, 127);

        // small table with a duplicate seed and seeds outside the cube
        load_seed(0, 0, 0, 0, 8'h00);
        load_seed(1, 15, 15, 15, 8'hff);
        load_seed(2, 8, 8, 8, 8'haa);
        load_seed(3, 127, 127, 127, 8'h55);
        load_seed(4, 0, 0, 0, 8'h3c);
        load_seed(255, 127, 0, 127, 8'hff);
        drain();
        write_reg(CFG_POINT_COUNT, 9'd5);
        query_cell(0, 0, 0);      // exact tie between slots 0 and 4
        query_cell(15, 0, 0);     // wraps round on x
        query_cell(15, 15, 15);
        query_cell(4, 4, 4);      // tie between slots 0, 2 and 4
        query_cell(8, 8, 8);
        query_cell(127, 127, 127);
        drain();

        // odd lengths: no folding, saturated distance, then zero length
        write_reg(CFG_GRID_LENGTH, 9'd255);
        write_reg(CFG_POINT_COUNT, 9'd1);
        query_cell(127, 127, 127);
        drain();
        write_reg(CFG_GRID_LENGTH, 9'd0);
        query_cell(100, 3, 60);
        drain();

        // random phases, each with its own geometry and search size
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: begin g = 1;   c = 8;   end
                1: begin g = 128; c = 256; end
                2: begin g = 2;   c = 1;   end
                3: begin g = 64;  c = 511; end
                4: begin g = 0;   c = 12;  end
                5: begin g = 255; c = 3;   end
                6: begin g = 32;  c = 0;   end
                default: begin
                    r = $urandom_range(0, 99);
                    g = (r < 85) ? (1 << $urandom_range(0, 7)) : $urandom_range(0, 255);
                    r = $urandom_range(0, 99);
                    if (r < 5)       c = 0;
                    else if (r < 12) c = $urandom_range(256, 511);
                    else             c = $urandom_range(1, 24);
                end
            endcase
            big = (c > 32);
            n   = (c > MAX_SEEDS) ? MAX_SEEDS : c;
            grid_now = g;
            steady   = 1'b0;

            // every searched slot must hold a seed before the count covers it
            for (int s = 0; s < n; s++)
                if (!loaded[s])
                    load_seed(SLOT_W'(s), rand_coord(), rand_coord(), rand_coord(),
                              LABEL_W'($urandom_range(0, 255)));
            drain();
            write_reg(CFG_GRID_LENGTH, {1'($urandom_range(0, 1)), 8'(g)});
            write_reg(CFG_POINT_COUNT, 9'(c));
            if (phase == 4) begin
                write_reg(CFG_SPARE_LO, 9'($urandom_range(0, 511)));
                write_reg(CFG_SPARE_HI, 9'($urandom_range(0, 511)));
            end

            // back-pressure phase: the result side holds off while queries wait at the input
            if (phase == 2) long_hold <= 1'b1;
            steady  = (phase == 2) || ($urandom_range(0, 3) == 0);
            n_items = big ? $urandom_range(4, 10) : $urandom_range(20, 50);
            repeat (n_items) begin
                if ($urandom_range(0, 9) < 7)
                    query_cell(rand_coord(), rand_coord(), rand_coord());
                else
                    load_seed(SLOT_W'($urandom_range(0, 255)), rand_coord(), rand_coord(),
                              rand_coord(), LABEL_W'($urandom_range(0, 255)));
            end
            drain();
            phase++;
        end

        repeat (SETTLE) @(posedge i_clk);
        if (failures == 0 && outstanding == 0)
            $display("toroidal_nearest_seed_search: match");
        else
            $display("toroidal_nearest_seed_search: mismatch");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/tnss_pkg.sv
hw/rtl/tnss_ram.sv
hw/rtl/tnss_axis_cell.sv
hw/rtl/toroidal_nearest_seed_search.sv
hw/rtl/tnss_checker.sv
tb/toroidal_nearest_seed_search_checker.sv
tb/toroidal_nearest_seed_search_test.sv
